[hw/rtl/sqvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvt_pkg
// Shared types, constants and the arctangent table of the sprite quad
// vertex transform.
// ----------------------------------------------------------------------------
package sqvt_pkg;

  // CORDIC rotation steps and sprite pipeline depth (prep + steps + final).
  localparam int CordicSteps = 20;
  localparam int SpriteLat   = CordicSteps + 2;

  // CORDIC start value: 1/K in Q2.30.
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;

  // Stream widths.
  localparam int InDataW  = 240;
  localparam int OutDataW = 136;

  // Corner codes.
  localparam logic [1:0] CornerTl = 2'd0;
  localparam logic [1:0] CornerTr = 2'd1;
  localparam logic [1:0] CornerBr = 2'd2;
  localparam logic [1:0] CornerBl = 2'd3;

  // Per-sprite values handed from the sprite pipeline to the corner pipeline.
  typedef struct packed {
    logic signed [39:0] bx;     // -origin_x * scale_x, Q.16
    logic signed [39:0] by;     // -origin_y * scale_y, Q.16
    logic signed [39:0] wx;     // scale_x * rect_width, Q.16
    logic signed [39:0] wy;     // scale_y * rect_height, Q.16
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic        [15:0] left;
    logic        [15:0] top;
    logic signed [15:0] rw;
    logic signed [15:0] rh;
    logic        [31:0] tint;
  } spr_t;

  // One corner result.
  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [17:0] tex_u;
    logic signed [17:0] tex_v;
    logic        [31:0] vert_color;
    logic        [1:0]  corner;
    logic               last;
  } vtx_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [33:0] atan_turn(input int i);
    logic signed [33:0] r;
    begin
      case (i)
        0:  r = 34'sh20000000;
        1:  r = 34'sh12E4051E;
        2:  r = 34'sh09FB385B;
        3:  r = 34'sh051111D4;
        4:  r = 34'sh028B0D43;
        5:  r = 34'sh0145D7E1;
        6:  r = 34'sh00A2F61E;
        7:  r = 34'sh00517C55;
        8:  r = 34'sh0028BE53;
        9:  r = 34'sh00145F2F;
        10: r = 34'sh000A2F98;
        11: r = 34'sh000517CC;
        12: r = 34'sh00028BE6;
        13: r = 34'sh000145F3;
        14: r = 34'sh0000A2FA;
        15: r = 34'sh0000517D;
        16: r = 34'sh000028BE;
        17: r = 34'sh0000145F;
        18: r = 34'sh00000A30;
        default: r = 34'sh00000518;
      endcase
      return r;
    end
  endfunction

endpackage

[hw/rtl/sqvt_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvt_cordic
// Pipelined sine and cosine of a 16-bit binary angle in Q1.15, one CORDIC
// step per stage, with the quarter turn applied exactly at the end.
// ----------------------------------------------------------------------------
module sqvt_cordic import sqvt_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [16:0] cos_q,
  output logic signed [16:0] sin_q
);

  logic signed [33:0] xr [0:CordicSteps];
  logic signed [33:0] yr [0:CordicSteps];
  logic signed [33:0] zr [0:CordicSteps];
  logic        [1:0]  qr [0:CordicSteps];
  logic               zf [0:CordicSteps];

  logic [16:0] qsum;
  logic [1:0]  q_in;
  logic [15:0] d_in;

  // Split the angle into the nearest quarter turn and a signed residue.
  always_comb begin
    qsum = {1'b0, angle} + 17'h02000;
    q_in = qsum[15:14];
    d_in = angle - {q_in, 14'd0};
  end

  assign xr[0] = CordicX0;
  assign yr[0] = '0;

  // Prep stage.
  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= {{2{d_in[15]}}, d_in, 16'd0};
      qr[0] <= q_in;
      zf[0] <= (d_in == 16'd0);
    end
  end

  // One rotation step per stage.
  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic signed [33:0] xs, ys;
    assign xs = xr[i] >>> i;
    assign ys = yr[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (i == 0) begin
          xr[i+1] <= (zr[i] >= 0) ? CordicX0 : CordicX0;
        end else if (zr[i] >= 0) begin
          xr[i+1] <= xr[i] - ys;
        end else begin
          xr[i+1] <= xr[i] + ys;
        end
        if (zr[i] >= 0) begin
          yr[i+1] <= yr[i] + xs;
          zr[i+1] <= zr[i] - atan_turn(i);
        end else begin
          yr[i+1] <= yr[i] - xs;
          zr[i+1] <= zr[i] + atan_turn(i);
        end
        qr[i+1] <= qr[i];
        zf[i+1] <= zf[i];
      end
    end
  end

  // Round to Q1.15, clamp, force an exact (1, 0) for a zero residue, then apply the quarter turn.
  logic signed [33:0] xrnd, yrnd;
  logic signed [16:0] cc, ss, cq, sq;

  always_comb begin
    xrnd = (xr[CordicSteps] + 34'sd16384) >>> 15;
    yrnd = (yr[CordicSteps] + 34'sd16384) >>> 15;
    if (xrnd > 34'sd32768)       cc = 17'sd32768;
    else if (xrnd < -34'sd32768) cc = -17'sd32768;
    else                         cc = xrnd[16:0];
    if (yrnd > 34'sd32768)       ss = 17'sd32768;
    else if (yrnd < -34'sd32768) ss = -17'sd32768;
    else                         ss = yrnd[16:0];
    if (zf[CordicSteps]) begin
      cc = 17'sd32768;
      ss = '0;
    end
    case (qr[CordicSteps])
      2'd1:    begin cq = -ss; sq = cc;  end
      2'd2:    begin cq = -cc; sq = -ss; end
      2'd3:    begin cq = ss;  sq = -cc; end
      default: begin cq = cc;  sq = ss;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= cq;
      sin_q <= sq;
    end
  end

endmodule

[hw/rtl/sqvt_corner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvt_corner
// Corner pipeline: local point, rotation products, sum with the position,
// rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module sqvt_corner import sqvt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  spr_t               spr,
  input  logic signed [16:0] cos_q,
  input  logic signed [16:0] sin_q,
  input  logic [1:0]         k,
  output logic               adv,
  output logic               out_vld,
  output vtx_t               out_vtx,
  input  logic               out_rdy
);

  assign adv = !out_vld || out_rdy;

  // Stage 1: local corner point and texture coordinate.
  logic               v1;
  logic signed [40:0] lx1, ly1;
  logic signed [16:0] c1, s1;
  logic signed [23:0] px1, py1;
  logic [17:0]        u1, w1;
  logic [31:0]        t1;
  logic [1:0]         k1;
  logic               right, bottom;

  assign right  = (k == CornerTr) || (k == CornerBr);
  assign bottom = (k == CornerBr) || (k == CornerBl);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lx1 <= 41'(spr.bx) + (right  ? 41'(spr.wx) : 41'sd0);
      ly1 <= 41'(spr.by) + (bottom ? 41'(spr.wy) : 41'sd0);
      u1  <= {2'b00, spr.left} + (right  ? {{2{spr.rw[15]}}, spr.rw} : 18'd0);
      w1  <= {2'b00, spr.top}  + (bottom ? {{2{spr.rh[15]}}, spr.rh} : 18'd0);
      c1  <= cos_q;
      s1  <= sin_q;
      px1 <= spr.px;
      py1 <= spr.py;
      t1  <= spr.tint;
      k1  <= k;
    end
  end

  // Stage 2: rotation products.
  logic               v2;
  logic signed [57:0] mxc, mys, mxs, myc;
  logic signed [23:0] px2, py2;
  logic [17:0]        u2, w2;
  logic [31:0]        t2;
  logic [1:0]         k2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mxc <= 58'(lx1) * 58'(c1);
      mys <= 58'(ly1) * 58'(s1);
      mxs <= 58'(lx1) * 58'(s1);
      myc <= 58'(ly1) * 58'(c1);
      px2 <= px1;
      py2 <= py1;
      u2  <= u1;
      w2  <= w1;
      t2  <= t1;
      k2  <= k1;
    end
  end

  // Stage 3: sums with the position and the rounding offset.
  logic               v3;
  logic signed [59:0] sx3, sy3;
  logic [17:0]        u3, w3;
  logic [31:0]        t3;
  logic [1:0]         k3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx3 <= 60'(mxc) - 60'(mys) + (60'(px2) <<< 23) + (60'sd1 <<< 22);
      sy3 <= 60'(mxs) + 60'(myc) + (60'(py2) <<< 23) + (60'sd1 <<< 22);
      u3  <= u2;
      w3  <= w2;
      t3  <= t2;
      k3  <= k2;
    end
  end

  // Stage 4: scale to Q.8 and saturate into the output register.
  logic signed [59:0] rx, ry;
  logic signed [31:0] satx, saty;

  always_comb begin
    rx = sx3 >>> 23;
    ry = sy3 >>> 23;
    if (rx > 60'sd2147483647)       satx = 32'sh7FFFFFFF;
    else if (rx < -60'sd2147483648) satx = 32'sh80000000;
    else                            satx = rx[31:0];
    if (ry > 60'sd2147483647)       saty = 32'sh7FFFFFFF;
    else if (ry < -60'sd2147483648) saty = 32'sh80000000;
    else                            saty = ry[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_vtx.vert_x     <= satx;
      out_vtx.vert_y     <= saty;
      out_vtx.tex_u      <= u3;
      out_vtx.tex_v      <= w3;
      out_vtx.vert_color <= t3;
      out_vtx.corner     <= k3;
      out_vtx.last       <= (k3 == CornerBl);
    end
  end

endmodule

[hw/rtl/sprite_quad_vertex_transform.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_quad_vertex_transform
// Turns one sprite into the four rotated, scaled and translated corners of
// its screen quad.
// ----------------------------------------------------------------------------
// Usage:
//   One sprite enters on the s_axis channel; four corner items leave on the
//   m_axis channel in the order top-left, top-right, bottom-right,
//   bottom-left, the last one marked by m_axis_tlast. m_axis_tuser carries
//   the corner index.
//   A sprite passes the input register, the CORDIC and delay stages, the
//   corner expander and the corner pipeline into the output register.
//   The output channel moves one corner item per cycle while the receiver
//   is ready; the corner expander holds a sprite through its four corners
//   while the CORDIC and product stages behind it hold their contents and
//   advance only when the expander takes its next sprite.
//   Sine and cosine come from 20 CORDIC rotation stages, one step per stage.
//   Reset clears all valid bits; no item is in flight afterward.
//   A receiver stall holds the whole pipeline and drops s_axis_tready, which
//   is also low while the expander holds a sprite with corners left.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_transform import sqvt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pos_x, pos_y, origin_x, origin_y, scale_x, scale_y, rect_left,
  // rect_top, rect_width, rect_height, tint, angle
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // vert_x, vert_y, tex_u, tex_v, vert_color, zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  // corner
  output logic [1:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  logic adv, sen, acc;
  logic sp_vld;
  logic [1:0] k;

  // The sprite pipeline moves when the expander can take its oldest sprite.
  assign sen           = adv && (!sp_vld || (k == CornerBl));
  assign s_axis_tready = sen;
  assign acc           = s_axis_tvalid && sen;

  // Valid bits of the sprite pipeline.
  logic [SpriteLat-1:0] vsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      vsh <= '0;
    end else if (sen) begin
      vsh <= {vsh[SpriteLat-2:0], acc};
    end
  end

  // Input register of the raw fields.
  logic signed [23:0] px0, py0, ox0, oy0;
  logic signed [15:0] scx0, scy0, rw0, rh0;
  logic [15:0]        left0, top0;
  logic [31:0]        tint0;

  always_ff @(posedge clk) begin
    if (sen) begin
      px0   <= s_axis_tdata[23:0];
      py0   <= s_axis_tdata[47:24];
      ox0   <= s_axis_tdata[71:48];
      oy0   <= s_axis_tdata[95:72];
      scx0  <= s_axis_tdata[111:96];
      scy0  <= s_axis_tdata[127:112];
      left0 <= s_axis_tdata[143:128];
      top0  <= s_axis_tdata[159:144];
      rw0   <= s_axis_tdata[175:160];
      rh0   <= s_axis_tdata[191:176];
      tint0 <= s_axis_tdata[223:192];
    end
  end

  // Sine and cosine run beside the payload with the same enable.
  logic signed [16:0] cos_q, sin_q;

  sqvt_cordic u_cordic (
    .clk   (clk),
    .en    (sen),
    .angle (s_axis_tdata[239:224]),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  // Origin and extent products, then a delay line to meet the CORDIC output.
  spr_t dl [1:SpriteLat-1];

  always_ff @(posedge clk) begin
    if (sen) begin
      dl[1].bx   <= -(40'(ox0) * 40'(scx0));
      dl[1].by   <= -(40'(oy0) * 40'(scy0));
      dl[1].wx   <= (40'(scx0) * 40'(rw0)) <<< 8;
      dl[1].wy   <= (40'(scy0) * 40'(rh0)) <<< 8;
      dl[1].px   <= px0;
      dl[1].py   <= py0;
      dl[1].left <= left0;
      dl[1].top  <= top0;
      dl[1].rw   <= rw0;
      dl[1].rh   <= rh0;
      dl[1].tint <= tint0;
    end
  end

  for (genvar i = 2; i < SpriteLat; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (sen) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  // Corner expander: holds one sprite and steps through its four corners.
  spr_t               sp;
  logic signed [16:0] sp_c, sp_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      sp_vld <= 1'b0;
      k      <= CornerTl;
    end else if (adv) begin
      if (!sp_vld || (k == CornerBl)) begin
        sp_vld <= vsh[SpriteLat-1];
        k      <= CornerTl;
      end else begin
        k <= k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sen) begin
      sp   <= dl[SpriteLat-1];
      sp_c <= cos_q;
      sp_s <= sin_q;
    end
  end

  // Corner pipeline and output register.
  vtx_t vtx;

  sqvt_corner u_corner (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (sp_vld),
    .spr     (sp),
    .cos_q   (sp_c),
    .sin_q   (sp_s),
    .k       (k),
    .adv     (adv),
    .out_vld (m_axis_tvalid),
    .out_vtx (vtx),
    .out_rdy (m_axis_tready)
  );

  assign m_axis_tdata = {4'd0, vtx.vert_color, vtx.tex_v, vtx.tex_u,
                         vtx.vert_y, vtx.vert_x};
  assign m_axis_tuser = vtx.corner;
  assign m_axis_tlast = vtx.last;

endmodule

[tb/sqvt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvt_checker
// This module watches both stream channels of the sprite quad vertex
// transform. For every sprite it takes in, it computes the four expected
// corners with its own fixed-point CORDIC and transform. It compares each
// corner item that leaves the block with the oldest expected corner.
// ----------------------------------------------------------------------------
module sqvt_checker import sqvt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic [1:0]          m_axis_tuser,
  input  logic                m_axis_tlast,
  output int                  mismatches,
  output int                  corners_due
);

  localparam int Steps = 20;

  // Arctangent of 2^-i, in units of 2^-32 turn.
  localparam longint AtanTurn [Steps] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518
  };

  vtx_t corner_q[$];
  int   fail_cnt = 0;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Cosine and sine in Q1.15: nearest quarter turn plus a CORDIC residue.
  function automatic void angle_cos_sin(input logic [15:0] ang,
                                        output longint c, output longint s);
    int          quad;
    logic [15:0] resid;
    longint      d, x, y, z, xs, ys, t;
    quad  = ((int'(ang) + 8192) >> 14) & 3;
    resid = ang - 16'(quad << 14);
    d     = longint'($signed(resid));
    if (d == 0) begin
      c = 32768;
      s = 0;
    end else begin
      x = 652032874;
      y = 0;
      z = d * 65536;
      for (int i = 0; i < Steps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - AtanTurn[i];
        end else begin
          x = x + ys; y = y - xs; z = z + AtanTurn[i];
        end
      end
      c = clip((x + 16384) >>> 15, -32768, 32768);
      s = clip((y + 16384) >>> 15, -32768, 32768);
    end
    case (quad)
      1: begin t = c; c = -s; s = t; end
      2: begin c = -c; s = -s; end
      3: begin t = c; c = s; s = -t; end
      default: ;
    endcase
  endfunction

  // Round a Q.31 sum to Q.8 and saturate to 32 bits.
  function automatic logic [31:0] round_sat(input longint acc);
    return 32'(clip((acc + (64'sd1 <<< 22)) >>> 23, -64'sd2147483648,
                    64'sd2147483647));
  endfunction

  // Queue the four corners of one sprite.
  task automatic queue_corners(input logic [InDataW-1:0] d);
    longint px, py, ox, oy, sx, sy, lft, tp, rw, rh, c, s, bx, by, wx, wy, lx, ly;
    vtx_t   v;
    logic   right, bottom;
    px  = longint'($signed(d[23:0]));
    py  = longint'($signed(d[47:24]));
    ox  = longint'($signed(d[71:48]));
    oy  = longint'($signed(d[95:72]));
    sx  = longint'($signed(d[111:96]));
    sy  = longint'($signed(d[127:112]));
    lft = longint'(d[143:128]);
    tp  = longint'(d[159:144]);
    rw  = longint'($signed(d[175:160]));
    rh  = longint'($signed(d[191:176]));
    angle_cos_sin(d[239:224], c, s);
    bx = -ox * sx;
    by = -oy * sy;
    wx = sx * rw * 256;
    wy = sy * rh * 256;
    for (int k = 0; k < 4; k++) begin
      right  = (k == 1 || k == 2);
      bottom = (k >= 2);
      lx = bx + (right ? wx : 0);
      ly = by + (bottom ? wy : 0);
      v.vert_x     = round_sat(lx * c - ly * s + px * (64'sd1 <<< 23));
      v.vert_y     = round_sat(lx * s + ly * c + py * (64'sd1 <<< 23));
      v.tex_u      = 18'(lft + (right ? rw : 0));
      v.tex_v      = 18'(tp + (bottom ? rh : 0));
      v.vert_color = d[223:192];
      v.corner     = 2'(k);
      v.last       = (k == 3);
      corner_q.insert(corner_q.size(), v);
    end
  endtask

  // Sprites in, corners out, compared at each accepted item.
  always @(posedge clk) begin
    vtx_t want, got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) queue_corners(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.vert_x     = m_axis_tdata[31:0];
        got.vert_y     = m_axis_tdata[63:32];
        got.tex_u      = m_axis_tdata[81:64];
        got.tex_v      = m_axis_tdata[99:82];
        got.vert_color = m_axis_tdata[131:100];
        got.corner     = m_axis_tuser;
        got.last       = m_axis_tlast;
        if (corner_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("ERROR: corner item with none expected");
        end else begin
          want = corner_q.pop_front();
          if (got != want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"ERROR: corner mismatch\n  exp x=%0d y=%0d u=%0d v=%0d ",
                        "col=%h c=%0d l=%0d\n  got x=%0d y=%0d u=%0d v=%0d ",
                        "col=%h c=%0d l=%0d"},
                       want.vert_x, want.vert_y, want.tex_u, want.tex_v,
                       want.vert_color, want.corner, want.last,
                       got.vert_x, got.vert_y, got.tex_u, got.tex_v,
                       got.vert_color, got.corner, got.last);
          end
        end
      end
    end
    mismatches  <= fail_cnt;
    corners_due <= corner_q.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench top of the sprite quad vertex transform. It drives directed and
// random sprites with random gaps and receiver stalls, and gives the verdict
// from the failure count and the outstanding corner count of the checker.
// ----------------------------------------------------------------------------
module tb;
  import sqvt_pkg::*;

  localparam int RandomSprites = 300;
  localparam int IdleLimit     = 3000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;
  int                  mismatches;
  int                  corners_due;

  // Receiver controls, set by the stimulus process.
  bit rx_free   = 1'b0;
  int long_reqs = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sprite_quad_vertex_transform dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  sqvt_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .mismatches(mismatches), .corners_due(corners_due)
  );

  // Receiver: mostly ready, short random stalls, rare long ones; on request a long stall or always ready.
  always @(posedge clk) begin
    static int hold_left = 0;
    static int long_seen = 0;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (long_reqs != long_seen) begin
      long_seen = long_reqs;
      hold_left = 300;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_free) begin
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 99) == 0) begin
      hold_left = $urandom_range(20, 60);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog on cycles with no accepted item on either channel.
  always @(posedge clk) begin
    static int idle_cycles = 0;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [InDataW-1:0] sprite(
      input logic [23:0] px, input logic [23:0] py,
      input logic [23:0] ox, input logic [23:0] oy,
      input logic [15:0] sx, input logic [15:0] sy,
      input logic [15:0] lft, input logic [15:0] tp,
      input logic [15:0] rw, input logic [15:0] rh,
      input logic [31:0] tint, input logic [15:0] ang);
    return {ang, tint, rh, rw, tp, lft, sy, sx, oy, ox, py, px};
  endfunction

  // A field value: often an extreme or small, otherwise full range.
  function automatic logic [31:0] field_value(input int w);
    logic [31:0] full;
    full = 32'({$urandom, $urandom} >> (32 - w));
    case ($urandom_range(0, 7))
      0: return 32'(1) << (w - 1);
      1: return (32'(1) << (w - 1)) - 1;
      2: return 32'(0) - 1;
      3: return 32'($urandom_range(0, 600)) - 300;
      default: return full;
    endcase
  endfunction

  function automatic logic [15:0] angle_value();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3) << 14);
      1: return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 4) - 2 + 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one sprite, wait for acceptance, then maybe leave a gap.
  task automatic send_sprite(input logic [InDataW-1:0] d);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    case ($urandom_range(0, 9))
      0, 1, 2: gap = $urandom_range(1, 3);
      3:       gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 0;
      default: gap = 0;
    endcase
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (corners_due != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sprites: quarter turns, residue edges, extremes, mirroring.
    send_sprite(sprite(24'h000100, 24'h000200, 24'd0, 24'd0, 16'h0100, 16'h0100,
                       16'd10, 16'd20, 16'd32, 16'd16, 32'h11223344, 16'h0000));
    send_sprite(sprite(24'h001000, 24'h002000, 24'h000800, 24'h000400, 16'h0100,
                       16'h0200, 16'd0, 16'd0, 16'd64, 16'd64, 32'hFFFFFFFF, 16'h4000));
    send_sprite(sprite(24'h001000, 24'h002000, 24'h000800, 24'h000400, 16'h0100,
                       16'h0200, 16'd0, 16'd0, 16'd64, 16'd64, 32'h0, 16'h8000));
    send_sprite(sprite(24'h001000, 24'h002000, 24'h000800, 24'h000400, 16'h0100,
                       16'h0200, 16'd0, 16'd0, 16'd64, 16'd64, 32'h0, 16'hC000));
    send_sprite(sprite(24'd0, 24'd0, 24'd0, 24'd0, 16'h0100, 16'h0100, 16'd5, 16'd5,
                       16'd8, 16'd8, 32'h5A5A5A5A, 16'h0001));
    send_sprite(sprite(24'd0, 24'd0, 24'd0, 24'd0, 16'h0100, 16'h0100, 16'd5, 16'd5,
                       16'd8, 16'd8, 32'hA5A5A5A5, 16'hFFFF));
    send_sprite(sprite(24'd0, 24'd0, 24'd0, 24'd0, 16'h0100, 16'h0100, 16'd5, 16'd5,
                       16'd8, 16'd8, 32'h1, 16'h1FFF));
    send_sprite(sprite(24'd0, 24'd0, 24'd0, 24'd0, 16'h0100, 16'h0100, 16'd5, 16'd5,
                       16'd8, 16'd8, 32'h2, 16'h2000));
    send_sprite(sprite(24'd0, 24'd0, 24'd0, 24'd0, 16'h0100, 16'h0100, 16'd5, 16'd5,
                       16'd8, 16'd8, 32'h3, 16'hE000));
    send_sprite(sprite(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 16'h7FFF,
                       16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF,
                       32'hFFFFFFFF, 16'h0000));
    send_sprite(sprite(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF,
                       16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h8000,
                       32'h0, 16'h0000));
    send_sprite(sprite(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h8000,
                       16'h8000, 16'hFFFF, 16'h0, 16'h7FFF, 16'h8000,
                       32'h80000001, 16'h6000));
    send_sprite(sprite(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 16'h8000,
                       16'h7FFF, 16'h0, 16'hFFFF, 16'h8000, 16'h7FFF,
                       32'h7FFFFFFE, 16'hA000));
    send_sprite(sprite(24'h000500, 24'h000500, 24'h000100, 24'h000100, 16'h0000,
                       16'h0000, 16'd7, 16'd9, 16'd0, 16'd0, 32'hCAFEF00D, 16'h1234));
    send_sprite(sprite(24'h000500, 24'h000500, 24'h000100, 24'h000100, 16'hFF00,
                       16'hFE80, 16'd7, 16'd9, 16'hFFF0, 16'hFFE0, 32'h0BADBEEF,
                       16'h9ABC));
    drain();

    // Random sprites, one long receiver stall while the sender keeps going.
    for (int n = 0; n < RandomSprites; n++) begin
      if (n == 100) long_reqs = long_reqs + 1;
      if (n == 180) drain();
      rx_free = (n >= 200 && n < 240);
      send_sprite(sprite(24'(field_value(24)), 24'(field_value(24)),
                         24'(field_value(24)), 24'(field_value(24)),
                         16'(field_value(16)), 16'(field_value(16)),
                         16'(field_value(16)), 16'(field_value(16)),
                         16'(field_value(16)), 16'(field_value(16)),
                         $urandom, angle_value()));
    end
    rx_free = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && corners_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/sqvt_pkg.sv
hw/rtl/sqvt_cordic.sv
hw/rtl/sqvt_corner.sv
hw/rtl/sprite_quad_vertex_transform.sv
tb/sqvt_checker.sv
tb/tb.sv
